### hw/rtl/tmf_pkg.sv
// Shared types, constants and helpers of the threshold median filter.
// No dependencies; imported by every module of the block.
package tmf_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_RADIUS        = 3;
   localparam int STORE_LINES       = 2 * MAX_RADIUS + 1;
   localparam int WIN_SIDE          = STORE_LINES;
   localparam int WIN_SIZE          = WIN_SIDE * WIN_SIDE;
   localparam int PIX_W             = 8;
   localparam int CFG_W             = 11;
   localparam int RAD_W             = 2;
   localparam int LINE_W            = $clog2(STORE_LINES);
   localparam int RANK_W            = $clog2(WIN_SIZE + 1);
   localparam int CNT_W             = $clog2(WIN_SIDE + 1);
   localparam int IDX_W             = 2;

   localparam logic [CFG_W-1:0] WIDTH_RESET     = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET    = 11'd480;
   localparam logic [RAD_W-1:0] RADIUS_RESET    = 2'd1;
   localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd42;

   typedef enum logic [IDX_W-1:0] {
      REG_IMAGE_WIDTH       = 2'd0,
      REG_IMAGE_HEIGHT      = 2'd1,
      REG_WINDOW_RADIUS     = 2'd2,
      REG_REPLACE_THRESHOLD = 2'd3
   } reg_index_type;

   typedef logic [LINE_W-1:0] line_type;
   typedef logic [STORE_LINES-1:0][PIX_W-1:0] column_type;

   // One window in flight through the rank selection chain
   typedef struct packed {
      logic [WIN_SIZE-1:0][PIX_W-1:0] pix;
      logic [WIN_SIZE-1:0]            mask;
      logic [RANK_W-1:0]              rank;
      logic [PIX_W-1:0]               median;
      logic [PIX_W-1:0]               centre;
      logic                           done;
   } cell_data_type;

   function automatic line_type line_next(line_type l);
      line_type n;
      if (l == line_type'(STORE_LINES - 1)) n = '0;
      else n = l + 1'b1;
      return n;
   endfunction

   // Line that lies k lines above line l in the circular store
   function automatic line_type line_back(line_type l, int k);
      logic [LINE_W:0] v;
      v = {1'b0, l} + (LINE_W + 1)'(STORE_LINES - k);
      if (v >= (LINE_W + 1)'(STORE_LINES)) v = v - (LINE_W + 1)'(STORE_LINES);
      return v[LINE_W-1:0];
   endfunction

   // Zero-based rank of the median among (2r+1)^2 values
   function automatic logic [RANK_W-1:0] median_rank(logic [RAD_W-1:0] r);
      logic [RANK_W:0] side;
      logic [2*RANK_W+1:0] area;
      side = (RANK_W + 1)'({r, 1'b1});
      area = side * side;
      return RANK_W'(area >> 1);
   endfunction

endpackage

### hw/rtl/threshold_median_filter.sv
// Threshold median filter: line store, 7x7 column-shift window, 8-cell rank chain.
// One item per cycle while req_stall is low, set by the single-port-per-line store and the
// 16-stage bit chain, both fully pipelined.
// Synchronous reset clears position and valid bits and loads the configuration defaults;
// line store is not cleared. A two-entry output (register plus skid) holds results under rsp_stall.
module threshold_median_filter
   import tmf_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PIX_W-1:0]  req_pixel_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PIX_W-1:0]  rsp_filtered_pixel,
   output logic              rsp_was_replaced,
   output logic              rsp_frame_done,
   input  logic              csr_write_enable,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             replaced;
      logic             done;
   } result_type;

   // Configuration
   logic [CFG_W-1:0] width_ff, height_ff;
   logic [RAD_W-1:0] radius_ff;
   logic [PIX_W-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         radius_ff    <= RADIUS_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH:       width_ff     <= csr_wdata;
            REG_IMAGE_HEIGHT:      height_ff    <= csr_wdata;
            REG_WINDOW_RADIUS:     radius_ff    <= csr_wdata[RAD_W-1:0];
            REG_REPLACE_THRESHOLD: threshold_ff <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   logic [WW-1:0]    w_eff;
   logic [CFG_W-1:0] h_eff;
   logic [2:0]       span;

   always_comb begin
      if (width_ff == '0) w_eff = WW'(1);
      else if (int'(width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_ff);
      h_eff = (height_ff == '0) ? CFG_W'(1) : height_ff;
      span  = {radius_ff, 1'b0};
   end

   // Position tracking
   logic             en, accept;
   logic [AW-1:0]    col_ff, col_in, cur_col;
   logic [CFG_W-1:0] row_ff, row_in, cur_row;
   line_type         line_ff, line_in, cur_line;
   logic [WW-1:0]    col_step;
   logic             emit, done;

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cur_col  = col_ff;
      cur_row  = row_ff;
      cur_line = line_ff;
      // wrap first if a narrower width or shorter height was written
      if (WW'(col_ff) >= w_eff) begin
         cur_col  = '0;
         cur_row  = row_ff + 1'b1;
         cur_line = line_next(line_ff);
      end
      if (cur_row >= h_eff) begin
         cur_row  = '0;
         cur_line = '0;
      end
      col_step = WW'(cur_col) + 1'b1;
      if (col_step >= w_eff) begin
         col_in  = '0;
         row_in  = cur_row + 1'b1;
         line_in = line_next(cur_line);
         if (row_in >= h_eff) begin
            row_in  = '0;
            line_in = '0;
         end
      end else begin
         col_in  = AW'(col_step);
         row_in  = cur_row;
         line_in = cur_line;
      end
      emit = (cur_row >= CFG_W'(span)) && (cur_col >= AW'(span));
      done = (cur_row == h_eff - 1'b1) && (WW'(cur_col) == w_eff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         line_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         line_ff <= line_in;
      end
   end

   // Line store
   column_type rd_data;

   tmf_line_store #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (accept),
      .wr_line(cur_line),
      .addr   (cur_col),
      .wr_data(req_pixel_in),
      .rd_en  (en),
      .rd_data(rd_data)
   );

   logic             p1_valid_ff, p1_emit_ff, p1_done_ff;
   logic [PIX_W-1:0] p1_pixel_ff;
   line_type         p1_line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_emit_ff  <= emit;
         p1_done_ff  <= done;
         p1_pixel_ff <= req_pixel_in;
         p1_line_ff  <= cur_line;
      end
   end

   // Window: row WIN_SIDE-1 is the current line, column WIN_SIDE-1 the newest
   column_type col_pix;
   logic [WIN_SIDE-1:0][WIN_SIDE-1:0][PIX_W-1:0] win_ff;
   logic p2_valid_ff, p2_done_ff;

   always_comb begin
      col_pix[WIN_SIDE-1] = p1_pixel_ff;
      for (int k = 1; k < WIN_SIDE; k++) begin
         col_pix[WIN_SIDE-1-k] = rd_data[line_back(p1_line_ff, k)];
      end
   end

   always_ff @(posedge clock) begin
      if (en && p1_valid_ff) begin
         for (int r = 0; r < WIN_SIDE; r++) begin
            for (int c = 0; c < WIN_SIDE - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
            win_ff[r][WIN_SIDE-1] <= col_pix[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff && p1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_done_ff <= p1_done_ff;
      end
   end

   // Rank selection chain
   logic          cell_valid [PIX_W+1];
   cell_data_type cell_data  [PIX_W+1];
   logic [2:0]    lo, ctr;

   always_comb begin
      lo  = 3'(WIN_SIDE - 1) - span;
      ctr = 3'(WIN_SIDE - 1) - 3'(radius_ff);
      cell_valid[0] = p2_valid_ff;
      for (int r = 0; r < WIN_SIDE; r++) begin
         for (int c = 0; c < WIN_SIDE; c++) begin
            cell_data[0].pix[r*WIN_SIDE+c]  = win_ff[r][c];
            cell_data[0].mask[r*WIN_SIDE+c] = (3'(r) >= lo) && (3'(c) >= lo);
         end
      end
      cell_data[0].rank   = median_rank(radius_ff);
      cell_data[0].median = '0;
      cell_data[0].centre = win_ff[ctr][ctr];
      cell_data[0].done   = p2_done_ff;
   end

   for (genvar i = 0; i < PIX_W; i++) begin : g_cell
      tmf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (cell_valid[i]),
         .in_data  (cell_data[i]),
         .out_valid(cell_valid[i+1]),
         .out_data (cell_data[i+1])
      );
   end

   // Decide and deliver
   result_type       fresh;
   logic [PIX_W-1:0] diff;
   logic             incoming;

   always_comb begin
      if (cell_data[PIX_W].centre > cell_data[PIX_W].median)
         diff = cell_data[PIX_W].centre - cell_data[PIX_W].median;
      else
         diff = cell_data[PIX_W].median - cell_data[PIX_W].centre;
      fresh.replaced = diff > threshold_ff;
      fresh.pixel    = fresh.replaced ? cell_data[PIX_W].median : cell_data[PIX_W].centre;
      fresh.done     = cell_data[PIX_W].done;
      incoming       = en && cell_valid[PIX_W];
   end

   logic       out_full_ff, skid_full_ff, pop;
   result_type out_ff, skid_ff;

   assign pop = out_full_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff  <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (pop && skid_full_ff) begin
         skid_full_ff <= 1'b0;
      end else if (pop) begin
         out_full_ff <= incoming;
      end else if (incoming) begin
         if (!out_full_ff) out_full_ff <= 1'b1;
         else skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_full_ff) begin
         out_ff <= skid_ff;
      end else if (incoming && (pop || !out_full_ff)) begin
         out_ff <= fresh;
      end else if (incoming) begin
         skid_ff <= fresh;
      end
   end

   assign rsp_valid          = out_full_ff;
   assign rsp_filtered_pixel = out_ff.pixel;
   assign rsp_was_replaced   = out_ff.replaced;
   assign rsp_frame_done     = out_ff.done;

   // Checks
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_full_ff)
      else $error("skid entry held while output register empty");

   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write_enable) |=> (WW'(col_ff) < w_eff))
      else $error("column position beyond line width after an item");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_ff < line_type'(STORE_LINES))
      else $error("line pointer outside the store");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> !accept && !incoming)
      else $error("item moved while output side full");

endmodule

### hw/rtl/tmf_line_store.sv
// Circular store of the most recent lines, one memory per line.
// Depends on tmf_pkg; one write and one registered read column per cycle.
module tmf_line_store
   import tmf_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  line_type                     wr_line,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  logic [PIX_W-1:0]             wr_data,
   input  logic                         rd_en,
   output column_type                   rd_data
);

   for (genvar i = 0; i < STORE_LINES; i++) begin : g_line
      logic [PIX_W-1:0] mem [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (wr_en && wr_line == line_type'(i)) begin
            mem[addr] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            rd_data[i] <= mem[addr];
         end
      end
   end

endmodule

### hw/rtl/tmf_cell.sv
// One bit step of the rank selection chain, most significant bit first.
// Depends on tmf_pkg; two register stages: row counts, then decide and narrow.
module tmf_cell
   import tmf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  cell_data_type in_data,
   output logic          out_valid,
   output cell_data_type out_data
);

   logic                                 a_valid_ff;
   cell_data_type                        a_data_ff;
   logic [WIN_SIDE-1:0][CNT_W-1:0]       cnt_ff;
   logic [WIN_SIDE-1:0][CNT_W-1:0]       cnt_in;
   logic                                 b_valid_ff;
   cell_data_type                        b_data_ff;
   cell_data_type                        b_data_in;
   logic [RANK_W-1:0]                    total;
   logic                                 bit_one;

   // Count candidates whose current top bit is zero, per window row
   always_comb begin
      for (int r = 0; r < WIN_SIDE; r++) begin
         cnt_in[r] = '0;
         for (int c = 0; c < WIN_SIDE; c++) begin
            cnt_in[r] = cnt_in[r] + CNT_W'(in_data.mask[r*WIN_SIDE+c] &
                                            ~in_data.pix[r*WIN_SIDE+c][PIX_W-1]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int r = 0; r < WIN_SIDE; r++) begin
         total = total + RANK_W'(cnt_ff[r]);
      end
      bit_one = !(a_data_ff.rank < total);
      b_data_in = a_data_ff;
      for (int i = 0; i < WIN_SIZE; i++) begin
         b_data_in.mask[i] = a_data_ff.mask[i] & (a_data_ff.pix[i][PIX_W-1] == bit_one);
         b_data_in.pix[i]  = {a_data_ff.pix[i][PIX_W-2:0], 1'b0};
      end
      b_data_in.rank   = bit_one ? a_data_ff.rank - total : a_data_ff.rank;
      b_data_in.median = {a_data_ff.median[PIX_W-2:0], bit_one};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_data_ff <= in_data;
         cnt_ff    <= cnt_in;
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule
